@@ rtl/core/pse_pkg.sv @@
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants of the postfix stack evaluator: request and
// result payloads, status and operation codes, state encodings.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned IT_W        = $clog2(DATA_W);

  localparam logic REQ_OPERAND   = 1'b0;
  localparam logic REQ_OPERATION = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } pse_op_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_MALFORMED = 3'd1,
    STAT_DIVZERO   = 3'd2,
    STAT_OVERFLOW  = 3'd3,
    STAT_FULL      = 3'd4
  } pse_status_e;

  typedef struct packed {
    logic               req_type;
    logic signed [63:0] operand_value;
    logic [2:0]         op_code;
    logic               last_token;
  } pse_req_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    pse_status_e        status;
  } pse_rsp_t;

  typedef struct packed {
    logic       start;
    logic [2:0] op_code;
  } pse_alu_ctl_t;

  typedef struct packed {
    logic        done;
    pse_status_e status;
  } pse_alu_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_FINISH
  } pse_state_e;

  typedef enum logic [2:0] {
    AL_IDLE,
    AL_ADD,
    AL_MUL,
    AL_DIV,
    AL_FIX,
    AL_DONE
  } pse_alu_state_e;

endpackage

@@ rtl/core/pse_ram.sv @@
// ----------------------------------------------------------------------------
// pse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/pse_alu.sv @@
// ----------------------------------------------------------------------------
// pse_alu
// Iterative arithmetic unit: add, subtract, radix-2 multiply, restoring
// divide and remainder, all on one shared 66-bit adder, with exact
// overflow detection for 64-bit signed results.
// ----------------------------------------------------------------------------
module pse_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pse_pkg::pse_alu_ctl_t ctl_i,
  input  logic [63:0]           opa_i,
  input  logic [63:0]           opb_i,
  output pse_pkg::pse_alu_rsp_t rsp_o,
  output logic [63:0]           res_o
);

  pse_pkg::pse_alu_state_e state_q, state_d;
  logic [2:0]                  op_q, op_d;
  logic                        an_q, an_d, bn_q, bn_d;
  logic [64:0]                 acc_q, acc_d;
  logic [63:0]                 shf_q, shf_d;
  logic [63:0]                 opd_q, opd_d;
  logic                        ovf_q, ovf_d;
  logic [pse_pkg::IT_W-1:0]    it_q, it_d;
  logic [63:0]                 res_q, res_d;
  pse_pkg::pse_status_e        st_q, st_d;

  logic [65:0] add_x, add_y, add_sum;
  logic        add_sub;
  logic [63:0] mag_a, mag_b;
  logic        neg;
  logic        last_it;

  assign mag_a   = opa_i[63] ? (64'd0 - opa_i) : opa_i;
  assign mag_b   = opb_i[63] ? (64'd0 - opb_i) : opb_i;
  assign neg     = an_q ^ bn_q;
  assign last_it = (it_q == pse_pkg::IT_W'(pse_pkg::DATA_W - 1));

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_q)
      pse_pkg::AL_ADD: begin
        add_x   = {{2{opd_q[63]}}, opd_q};
        add_y   = {{2{shf_q[63]}}, shf_q};
        add_sub = (op_q == pse_pkg::OP_SUB);
      end
      pse_pkg::AL_MUL: begin
        add_x = {1'b0, acc_q[63:0], 1'b0};
        add_y = shf_q[63] ? {2'b00, opd_q} : '0;
      end
      pse_pkg::AL_DIV: begin
        add_x   = {1'b0, acc_q[63:0], shf_q[63]};
        add_y   = {2'b00, opd_q};
        add_sub = 1'b1;
      end
      pse_pkg::AL_FIX: begin
        add_sub = 1'b1;
        if (op_q == pse_pkg::OP_MOD) begin
          add_x = {2'b00, opd_q};
          add_y = {2'b00, acc_q[63:0]};
        end else if (op_q == pse_pkg::OP_MUL) begin
          add_y = {2'b00, acc_q[63:0]};
        end else begin
          add_y = {2'b00, shf_q};
        end
      end
      default: begin
      end
    endcase
  end

  assign add_sum = add_x + (add_y ^ {66{add_sub}}) + 66'(add_sub);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pse_pkg::AL_IDLE: begin
        if (ctl_i.start) begin
          unique case (ctl_i.op_code) inside
            pse_pkg::OP_ADD, pse_pkg::OP_SUB: state_d = pse_pkg::AL_ADD;
            pse_pkg::OP_MUL:                  state_d = pse_pkg::AL_MUL;
            pse_pkg::OP_DIV, pse_pkg::OP_MOD: begin
              state_d = (opb_i == 64'd0) ? pse_pkg::AL_DONE : pse_pkg::AL_DIV;
            end
            default:                          state_d = pse_pkg::AL_DONE;
          endcase
        end
      end
      pse_pkg::AL_ADD:  state_d = pse_pkg::AL_DONE;
      pse_pkg::AL_MUL,
      pse_pkg::AL_DIV: begin
        if (last_it) state_d = pse_pkg::AL_FIX;
      end
      pse_pkg::AL_FIX:  state_d = pse_pkg::AL_DONE;
      pse_pkg::AL_DONE: state_d = pse_pkg::AL_IDLE;
      default:          state_d = pse_pkg::AL_IDLE;
    endcase
  end

  always_comb begin
    op_d  = op_q;
    an_d  = an_q;
    bn_d  = bn_q;
    acc_d = acc_q;
    shf_d = shf_q;
    opd_d = opd_q;
    ovf_d = ovf_q;
    it_d  = it_q;
    res_d = res_q;
    st_d  = st_q;
    unique case (state_q)
      pse_pkg::AL_IDLE: begin
        if (ctl_i.start) begin
          op_d  = ctl_i.op_code;
          an_d  = opa_i[63];
          bn_d  = opb_i[63];
          acc_d = '0;
          ovf_d = 1'b0;
          it_d  = '0;
          res_d = '0;
          st_d  = pse_pkg::STAT_OK;
          unique case (ctl_i.op_code) inside
            pse_pkg::OP_ADD, pse_pkg::OP_SUB: begin
              opd_d = opa_i;
              shf_d = opb_i;
            end
            pse_pkg::OP_MUL: begin
              opd_d = mag_a;
              shf_d = mag_b;
            end
            pse_pkg::OP_DIV, pse_pkg::OP_MOD: begin
              opd_d = mag_b;
              shf_d = mag_a;
              if (opb_i == 64'd0) st_d = pse_pkg::STAT_DIVZERO;
            end
            default: begin
            end
          endcase
        end
      end
      pse_pkg::AL_ADD: begin
        res_d = add_sum[63:0];
        st_d  = (add_sum[65] == add_sum[64] && add_sum[64] == add_sum[63]) ?
                pse_pkg::STAT_OK : pse_pkg::STAT_OVERFLOW;
      end
      pse_pkg::AL_MUL: begin
        acc_d = add_sum[64:0];
        ovf_d = ovf_q | add_sum[64] | (add_sum[63] & (|add_sum[62:0]));
        shf_d = {shf_q[62:0], 1'b0};
        it_d  = it_q + pse_pkg::IT_W'(1);
      end
      pse_pkg::AL_DIV: begin
        acc_d = add_sum[65] ? {acc_q[63:0], shf_q[63]} : add_sum[64:0];
        shf_d = {shf_q[62:0], ~add_sum[65]};
        it_d  = it_q + pse_pkg::IT_W'(1);
      end
      pse_pkg::AL_FIX: begin
        case (op_q)
          pse_pkg::OP_MUL: begin
            st_d  = (ovf_q | (~neg & acc_q[63])) ?
                    pse_pkg::STAT_OVERFLOW : pse_pkg::STAT_OK;
            res_d = neg ? add_sum[63:0] : acc_q[63:0];
          end
          pse_pkg::OP_DIV: begin
            st_d  = (~neg & shf_q[63]) ? pse_pkg::STAT_OVERFLOW : pse_pkg::STAT_OK;
            res_d = neg ? add_sum[63:0] : shf_q;
          end
          pse_pkg::OP_MOD: begin
            st_d  = pse_pkg::STAT_OK;
            res_d = (an_q && (|acc_q[63:0])) ? add_sum[63:0] : acc_q[63:0];
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pse_pkg::AL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    an_q  <= an_d;
    bn_q  <= bn_d;
    acc_q <= acc_d;
    shf_q <= shf_d;
    opd_q <= opd_d;
    ovf_q <= ovf_d;
    it_q  <= it_d;
    res_q <= res_d;
    st_q  <= st_d;
  end

  assign rsp_o.done   = (state_q == pse_pkg::AL_DONE);
  assign rsp_o.status = st_q;
  assign res_o        = res_q;

endmodule

@@ rtl/core/postfix_stack_evaluator_top.sv @@
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_top
// Postfix expression evaluator over signed 64-bit integers: bounded value
// stack in RAM, cached top of stack, iterative shared arithmetic unit.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  request   in         in_valid_i / in_ready_o    in_req_i   (pse_req_t)
//  result    out        out_valid_o / out_ready_i  out_rsp_o  (pse_rsp_t)
//
//  Operand token or ignored token: idle and finish steps. Add or subtract:
//  fetch, execute and finish steps. Multiply, divide, modulo: one pass per
//  operand bit through the shared adder, plus setup, fix-up and write-back.
//  Reset clears count, error, sequencer and output valid; stack RAM is not
//  cleared, the count marks which entries are live.
//  A last token holds in its final step while the previous result waits.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pse_pkg::pse_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pse_pkg::pse_rsp_t out_rsp_o
);

  pse_pkg::pse_state_e       state_q, state_d;
  logic [pse_pkg::CNT_W-1:0] cnt_q, cnt_d;
  pse_pkg::pse_status_e      err_q, err_d;
  logic [63:0]               top_q, top_d;
  pse_pkg::pse_req_t         req_q, req_d;
  logic                      out_valid_q, out_valid_d;
  pse_pkg::pse_rsp_t         out_rsp_q, out_rsp_d;

  logic [pse_pkg::CNT_W-1:0]  cnt_m2;
  logic                       ram_we, ram_re;
  logic [pse_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [63:0]                ram_wdata, ram_rdata;
  pse_pkg::pse_alu_ctl_t      alu_ctl;
  pse_pkg::pse_alu_rsp_t      alu_rsp;
  logic [63:0]                alu_res;
  pse_pkg::pse_status_e       fin_status;
  logic                       short_path;
  logic                       slot_free;

  assign cnt_m2     = cnt_q - pse_pkg::CNT_W'(2);
  assign slot_free  = ~out_valid_q | out_ready_i;
  assign short_path = (err_q != pse_pkg::STAT_OK) ||
                      (in_req_i.req_type == pse_pkg::REQ_OPERAND) ||
                      (cnt_q < pse_pkg::CNT_W'(2));
  assign fin_status = (err_q != pse_pkg::STAT_OK) ? err_q :
                      (cnt_q == '0) ? pse_pkg::STAT_MALFORMED : pse_pkg::STAT_OK;

  pse_ram #(
    .WIDTH (pse_pkg::DATA_W),
    .DEPTH (pse_pkg::STACK_DEPTH)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign alu_ctl.start   = (state_q == pse_pkg::ST_FETCH);
  assign alu_ctl.op_code = req_q.op_code;

  pse_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl),
    .opa_i  (ram_rdata),
    .opb_i  (top_q),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pse_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = short_path ? pse_pkg::ST_FINISH : pse_pkg::ST_FETCH;
        end
      end
      pse_pkg::ST_FETCH: state_d = pse_pkg::ST_EXEC;
      pse_pkg::ST_EXEC: begin
        if (alu_rsp.done) state_d = pse_pkg::ST_FINISH;
      end
      pse_pkg::ST_FINISH: begin
        if (!req_q.last_token || slot_free) state_d = pse_pkg::ST_IDLE;
      end
      default: state_d = pse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[pse_pkg::ADDR_W-1:0];
    ram_wdata   = in_req_i.operand_value;
    ram_re      = 1'b0;
    ram_raddr   = cnt_m2[pse_pkg::ADDR_W-1:0];
    cnt_d       = cnt_q;
    err_d       = err_q;
    top_d       = top_q;
    req_d       = req_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_rsp_d   = out_rsp_q;
    unique case (state_q)
      pse_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          if (err_q == pse_pkg::STAT_OK) begin
            if (in_req_i.req_type == pse_pkg::REQ_OPERAND) begin
              if (cnt_q == pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH)) begin
                err_d = pse_pkg::STAT_FULL;
              end else begin
                ram_we = 1'b1;
                top_d  = in_req_i.operand_value;
                cnt_d  = cnt_q + pse_pkg::CNT_W'(1);
              end
            end else if (cnt_q < pse_pkg::CNT_W'(2)) begin
              err_d = pse_pkg::STAT_MALFORMED;
            end else begin
              ram_re = 1'b1;
            end
          end
        end
      end
      pse_pkg::ST_FETCH: begin
      end
      pse_pkg::ST_EXEC: begin
        if (alu_rsp.done) begin
          if (alu_rsp.status == pse_pkg::STAT_OK) begin
            cnt_d     = cnt_q - pse_pkg::CNT_W'(1);
            ram_we    = 1'b1;
            ram_waddr = cnt_m2[pse_pkg::ADDR_W-1:0];
            ram_wdata = alu_res;
            top_d     = alu_res;
          end else begin
            err_d = alu_rsp.status;
          end
        end
      end
      pse_pkg::ST_FINISH: begin
        if (req_q.last_token && slot_free) begin
          out_valid_d            = 1'b1;
          out_rsp_d.status       = fin_status;
          out_rsp_d.result_value = (fin_status == pse_pkg::STAT_OK) ? top_q : 64'd0;
          cnt_d                  = '0;
          err_d                  = pse_pkg::STAT_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pse_pkg::ST_IDLE;
      cnt_q       <= '0;
      err_q       <= pse_pkg::STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    req_q     <= req_d;
    out_rsp_q <= out_rsp_d;
  end

  assign in_ready_o  = (state_q == pse_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_rsp_q.status != pse_pkg::STAT_OK) |->
      out_rsp_q.result_value == 64'sd0)
    else $error("error result carries nonzero value");

  a_alu_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_ctl.start |-> (cnt_q >= pse_pkg::CNT_W'(2)) && (err_q == pse_pkg::STAT_OK))
    else $error("operation started without two operands");

  a_done_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> state_q == pse_pkg::ST_EXEC)
    else $error("arithmetic unit finished outside execute step");

  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pse_pkg::ST_FINISH) && !req_q.last_token |=>
      (state_q == pse_pkg::ST_IDLE) && (out_valid_q == $past(out_valid_d)))
    else $error("non-final token left finish step wrongly");

endmodule
